>>> sv/u64alu_pkg.sv
package u64alu_pkg;

   localparam int WORD_W      = 64;
   localparam int STEPS       = WORD_W;
   localparam int CNT_W       = $clog2(STEPS);
   localparam int CMD_W       = 3;
   localparam int SHAMT_W     = 32;
   localparam int MAX_SHIFT   = WORD_W - 1;
   localparam int SHIFT_SEL_W = $clog2(WORD_W);

   // operation codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_REM = 3'd4,
      CMD_SHL = 3'd5,
      CMD_SHR = 3'd6
   } cmd_type;

   // top level to engine
   typedef struct packed {
      logic start;
      logic ack;
   } eng_ctl_type;

   // engine to top level
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

>>> sv/u64alu_engine.sv
module u64alu_engine
   import u64alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  eng_ctl_type         ctl,
   input  logic [CMD_W-1:0]    op_command,
   input  logic [WORD_W-1:0]   op_a,
   input  logic [WORD_W-1:0]   op_b,
   output eng_stat_type        stat,
   output logic [WORD_W-1:0]   result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // shared adder/subtractor operands
   logic [WORD_W:0]     add_x;
   logic [WORD_W:0]     add_y;
   logic                add_sub;
   logic [WORD_W+1:0]   add_sum;

   logic                no_borrow;
   logic [WORD_W-1:0]   rem_step;
   logic [WORD_W-1:0]   quo_step;
   logic [SHAMT_W-1:0]  shamt;
   logic                shamt_over;
   logic [WORD_W-1:0]   shl_val;
   logic [WORD_W-1:0]   shr_val;
   logic                last_step;

   // steer the shared adder
   always_comb begin
      add_x   = {1'b0, op_a};
      add_y   = {1'b0, op_b};
      add_sub = 1'b0;
      if (state_ff == ST_IDLE) begin
         add_sub = (cmd_type'(op_command) == CMD_SUB);
      end else if (cmd_type'(cmd_ff) == CMD_MUL) begin
         add_x = {1'b0, acc_ff};
         add_y = b_ff[0] ? {1'b0, a_ff} : '0;
      end else begin
         // trial subtract of the divisor from the shifted partial remainder
         add_x   = {acc_ff, a_ff[WORD_W-1]};
         add_y   = {1'b0, b_ff};
         add_sub = 1'b1;
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(WORD_W+1){add_sub}}}
                    + (WORD_W+2)'(add_sub);

   // restoring divide step
   assign no_borrow = add_sum[WORD_W+1];
   assign rem_step  = no_borrow ? add_sum[WORD_W-1:0] : {acc_ff[WORD_W-2:0], a_ff[WORD_W-1]};
   assign quo_step  = {a_ff[WORD_W-2:0], no_borrow};

   // logical shifts by the low 32 bits of operand b
   assign shamt      = op_b[SHAMT_W-1:0];
   assign shamt_over = (shamt > SHAMT_W'(MAX_SHIFT));
   assign shl_val    = shamt_over ? '0 : (op_a << shamt[SHIFT_SEL_W-1:0]);
   assign shr_val    = shamt_over ? '0 : (op_a >> shamt[SHIFT_SEL_W-1:0]);

   assign last_step = (cnt_ff == CNT_W'(STEPS - 1));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               cmd_in   = op_command;
               a_in     = op_a;
               b_in     = op_b;
               cnt_in   = '0;
               state_in = ST_DONE;
               case (cmd_type'(op_command))
                  CMD_ADD, CMD_SUB: begin
                     acc_in = add_sum[WORD_W-1:0];
                  end
                  CMD_MUL: begin
                     acc_in   = '0;
                     state_in = ST_RUN;
                  end
                  CMD_DIV, CMD_REM: begin
                     if (op_b == '0) begin
                        // divide by zero: all ones, or zero for zero over zero
                        acc_in = (op_a == '0) ? '0 : '1;
                     end else begin
                        acc_in   = '0;
                        state_in = ST_RUN;
                     end
                  end
                  CMD_SHL: begin
                     acc_in = shl_val;
                  end
                  CMD_SHR: begin
                     acc_in = shr_val;
                  end
                  default: begin
                     acc_in = '0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cmd_type'(cmd_ff) == CMD_MUL) begin
               // accumulate and advance the multiplier bits
               acc_in = add_sum[WORD_W-1:0];
               a_in   = {a_ff[WORD_W-2:0], 1'b0};
               b_in   = {1'b0, b_ff[WORD_W-1:1]};
            end else begin
               a_in   = quo_step;
               acc_in = rem_step;
               if (last_step && cmd_type'(cmd_ff) == CMD_DIV) begin
                  acc_in = quo_step;
               end
            end
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign result    = acc_ff;

endmodule

>>> sv/unsigned_64bit_alu_with_divide.sv
// Channel  Ports                                          Direction
// req      req_valid/req_ready, req_command,
//          req_operand_a, req_operand_b                   in
// rsp      rsp_valid/rsp_ready, rsp_result                out
//
// Add, subtract, shifts, divide by zero and the unused code finish at accept;
// multiply and divide/remainder first run the 64 shift-add or trial-subtract
// steps through one shared adder. req_ready returns the cycle after the
// engine hands its result to the output register, so a new request waits until
// the last one leaves the engine. A stalled rsp side holds one result in the
// output register and one in the engine, then holds off req.
// Synchronous active-high reset clears the sequencer and rsp_valid.
module unsigned_64bit_alu_with_divide
   import u64alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [WORD_W-1:0]   req_operand_a,
   input  logic [WORD_W-1:0]   req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_result
);

   eng_ctl_type         eng_ctl;
   eng_stat_type        eng_stat;
   logic [WORD_W-1:0]   eng_result;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_result_ff, rsp_result_in;
   logic                load_out;

   assign req_ready     = eng_stat.idle;
   assign load_out      = eng_stat.done && (!rsp_valid_ff || rsp_ready);
   assign eng_ctl.start = req_valid && req_ready;
   assign eng_ctl.ack   = load_out;

   u64alu_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .ctl        (eng_ctl),
      .op_command (req_command),
      .op_a       (req_operand_a),
      .op_b       (req_operand_b),
      .stat       (eng_stat),
      .result     (eng_result)
   );

   // output register: load a finished result, drop it once taken
   assign rsp_valid_in  = load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_result_in = load_out ? eng_result : rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef SYNTHESIS
   // engine leaves idle once a beat is taken
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine still idle after accepting a beat");

   // a finished result waits in the engine until the output register takes it
   a_done_held : assert property (@(posedge clock) disable iff (reset)
      (eng_stat.done && !eng_ctl.ack) |=> eng_stat.done)
      else $error("finished result dropped before hand-off");

   // hand-off only from a finished engine
   a_ack_needs_done : assert property (@(posedge clock) disable iff (reset)
      eng_ctl.ack |-> eng_stat.done)
      else $error("hand-off without a finished result");

   // idle and done never together
   a_idle_done_excl : assert property (@(posedge clock) disable iff (reset)
      $onehot0({eng_stat.idle, eng_stat.done}))
      else $error("engine idle and done at once");
`endif

endmodule
